// File: rtl/ocsp_pkg.sv
// ----------------------------------------------------------------------------
// ocsp_pkg
// Types, codes, constants and helper functions for the orbit camera
// position unit.
// ----------------------------------------------------------------------------
package ocsp_pkg;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_UPDATE,
        S_WRAP,
        S_ROT_INIT,
        S_ROT_ITER,
        S_ROT_DONE,
        S_MUL_RS,
        S_MUL_X,
        S_MUL_Y,
        S_MUL_Z,
        S_FIN_Z,
        S_OUT
    } t_state;

    // command modes
    localparam logic [2:0] MODE_SET_RADIUS = 3'd0;
    localparam logic [2:0] MODE_SET_PHI    = 3'd1;
    localparam logic [2:0] MODE_SET_THETA  = 3'd2;
    localparam logic [2:0] MODE_ADD_RADIUS = 3'd3;
    localparam logic [2:0] MODE_SUB_PHI    = 3'd4;
    localparam logic [2:0] MODE_ADD_THETA  = 3'd5;

    // register indexes (word address)
    localparam logic [1:0] REG_CENTER_X = 2'd0;
    localparam logic [1:0] REG_CENTER_Y = 2'd1;
    localparam logic [1:0] REG_CENTER_Z = 2'd2;

    // state reset values
    localparam logic signed [15:0] RADIUS_RESET = 16'sd512;
    localparam logic [13:0]        PHI_RESET    = 14'd9651;
    localparam logic [14:0]        THETA_RESET  = 15'd12868;

    // angle limits in Q4.12
    localparam logic signed [17:0] PHI_MIN    = 18'sd41;
    localparam logic signed [17:0] PHI_MAX    = 18'sd12827;
    localparam logic signed [16:0] THETA_WRAP = 17'sd25736;

    // cordic constants in Q.28
    localparam logic signed [31:0] PI_Q28         = 32'sd843314857;
    localparam logic signed [31:0] HALF_PI_Q28    = 32'sd421657429;
    localparam logic signed [31:0] THR_HALF_PI_Q28 = 32'sd1264972286;
    localparam logic signed [31:0] TWO_PI_Q28     = 32'sd1686629714;
    localparam logic signed [31:0] GAIN_Q28       = 32'sd163008218;

    // arctangent of 2^-i in Q.28
    function automatic logic signed [31:0] atan_q28(input logic [4:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:  v = 32'sd210828714;
            5'd1:  v = 32'sd124459457;
            5'd2:  v = 32'sd65760959;
            5'd3:  v = 32'sd33381290;
            5'd4:  v = 32'sd16755422;
            5'd5:  v = 32'sd8385879;
            5'd6:  v = 32'sd4193963;
            5'd7:  v = 32'sd2097109;
            5'd8:  v = 32'sd1048571;
            5'd9:  v = 32'sd524287;
            5'd10: v = 32'sd262144;
            5'd11: v = 32'sd131072;
            5'd12: v = 32'sd65536;
            5'd13: v = 32'sd32768;
            5'd14: v = 32'sd16384;
            5'd15: v = 32'sd8192;
            5'd16: v = 32'sd4096;
            5'd17: v = 32'sd2048;
            5'd18: v = 32'sd1024;
            5'd19: v = 32'sd512;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // clamp a signed angle into the polar range
    function automatic logic [13:0] clamp_phi(input logic signed [17:0] v);
        logic [13:0] r;
        if (v < PHI_MIN) begin
            r = PHI_MIN[13:0];
        end else if (v > PHI_MAX) begin
            r = PHI_MAX[13:0];
        end else begin
            r = v[13:0];
        end
        return r;
    endfunction

    // saturate to the signed 18-bit position range
    function automatic logic signed [17:0] sat18(input logic signed [22:0] v);
        logic signed [17:0] r;
        if (v > 23'sd131071) begin
            r = 18'sd131071;
        end else if (v < -23'sd131072) begin
            r = -18'sd131072;
        end else begin
            r = v[17:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/ocsp_if.sv
// ----------------------------------------------------------------------------
// ocsp_if
// Valid/ready channels of the orbit camera position unit: the command
// channel and the position channel.
// ----------------------------------------------------------------------------

// command word: mode and operand
interface ocsp_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         mode;
    logic signed [15:0] operand_value;

    modport source (output valid, mode, operand_value, input ready);
    modport sink   (input valid, mode, operand_value, output ready);
endinterface

// position word: camera position and current orbit state
interface ocsp_pos_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] pos_x;
    logic signed [17:0] pos_y;
    logic signed [17:0] pos_z;
    logic signed [15:0] cur_radius;
    logic [13:0]        cur_phi;
    logic [14:0]        cur_theta;

    modport source (output valid, pos_x, pos_y, pos_z, cur_radius, cur_phi, cur_theta,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, cur_radius, cur_phi, cur_theta,
                    output ready);
endinterface

// File: rtl/orbit_camera_spherical_position.sv
// ----------------------------------------------------------------------------
// orbit_camera_spherical_position
// Orbit camera: keeps radius, polar and azimuth angle, and gives the camera
// position from them through one shared iterative cordic and multiplier.
// ----------------------------------------------------------------------------
// Usage
//   i_cmd  : command word (mode, operand_value). Taken while the sequencer is
//            idle; modes set or step radius, phi or theta.
//   o_pos  : one position word per command: centre plus spherical position,
//            together with the updated radius, phi and theta.
//   apb    : centre x/y/z at byte addresses 0, 4, 8; write only when idle.
// Sequence: the cordic rotator runs phi and then theta, one micro-rotation
//   a cycle, and the single multiplier takes four products in turn.
// Throughput: one command at a time; the sequencer is ready again in the
//   cycle after the word is loaded into the output register.
// Reset: radius 512, phi 3pi/4, theta pi, centre at the origin, no word held.
// Stall: the output register holds its word until taken; a finished second
//   result waits in the sequencer and no further command is taken.
// ----------------------------------------------------------------------------
module orbit_camera_spherical_position
    import ocsp_pkg::*;
#(
    parameter int CORDIC_ITERS = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ocsp_cmd_if.sink           i_cmd,
    ocsp_pos_if.source         o_pos,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int ITER_W = $clog2(CORDIC_ITERS);

    // state registers
    t_state              r_state, n_state;
    logic signed [15:0]  r_radius, n_radius;
    logic [13:0]         r_phi, n_phi;
    logic [14:0]         r_theta, n_theta;
    logic signed [15:0]  r_center_x, r_center_y, r_center_z;
    logic                r_out_valid, n_out_valid;

    // working registers
    logic [2:0]          r_mode;
    logic signed [15:0]  r_op;
    logic signed [16:0]  r_wrap, n_wrap;
    logic                r_pass, n_pass;
    logic                r_neg, n_neg;
    logic [ITER_W-1:0]   r_iter, n_iter;
    logic signed [31:0]  r_x, n_x, r_y, n_y, r_z, n_z;
    logic signed [17:0]  r_cos_phi, n_cos_phi, r_sin_phi, n_sin_phi;
    logic signed [17:0]  r_cos_th, n_cos_th, r_sin_th, n_sin_th;
    logic signed [31:0]  r_rs, n_rs;
    logic signed [49:0]  r_prod, n_prod;
    logic signed [17:0]  r_px, n_px, r_py, n_py, r_pz, n_pz;
    logic signed [17:0]  r_out_x, n_out_x, r_out_y, n_out_y, r_out_z, n_out_z;
    logic signed [15:0]  r_out_r, n_out_r;
    logic [13:0]         r_out_phi, n_out_phi;
    logic [14:0]         r_out_th, n_out_th;

    // combinational helpers
    logic                w_cfg_wr;
    logic                w_load_out;
    logic [14:0]         w_angle;
    logic signed [31:0]  w_z0;
    logic [4:0]          w_sh;
    logic signed [31:0]  w_xf, w_yf, w_crnd, w_srnd;
    logic signed [31:0]  w_mul_a;
    logic signed [17:0]  w_mul_b;
    logic signed [49:0]  w_prod, w_rnd28, w_rnd14;
    logic signed [21:0]  w_rnd;
    logic signed [15:0]  w_ctr;
    logic signed [17:0]  w_fin;
    logic signed [16:0]  w_rsum;
    logic signed [17:0]  w_phi_diff;

    // apb port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[3:2])
            REG_CENTER_X: prdata = 32'(r_center_x);
            REG_CENTER_Y: prdata = 32'(r_center_y);
            REG_CENTER_Z: prdata = 32'(r_center_z);
            default:      prdata = 32'd0;
        endcase
    end

    // handshake outputs
    assign i_cmd.ready      = (r_state == S_IDLE);
    assign o_pos.valid      = r_out_valid;
    assign o_pos.pos_x      = r_out_x;
    assign o_pos.pos_y      = r_out_y;
    assign o_pos.pos_z      = r_out_z;
    assign o_pos.cur_radius = r_out_r;
    assign o_pos.cur_phi    = r_out_phi;
    assign o_pos.cur_theta  = r_out_th;

    assign w_load_out = (r_state == S_OUT) && (!r_out_valid || o_pos.ready);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) n_state = S_UPDATE;
            end
            S_UPDATE: n_state = S_WRAP;
            S_WRAP: begin
                if (!r_wrap[16] && (r_wrap < THETA_WRAP)) n_state = S_ROT_INIT;
            end
            S_ROT_INIT: n_state = S_ROT_ITER;
            S_ROT_ITER: begin
                if (r_iter == ITER_W'(CORDIC_ITERS - 1)) n_state = S_ROT_DONE;
            end
            S_ROT_DONE: n_state = r_pass ? S_MUL_RS : S_ROT_INIT;
            S_MUL_RS:   n_state = S_MUL_X;
            S_MUL_X:    n_state = S_MUL_Y;
            S_MUL_Y:    n_state = S_MUL_Z;
            S_MUL_Z:    n_state = S_FIN_Z;
            S_FIN_Z:    n_state = S_OUT;
            S_OUT: begin
                if (w_load_out) n_state = S_IDLE;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // cordic start angle, folded into [-pi/2, pi/2] when the rotator is loaded
    assign w_angle = r_pass ? r_theta : {1'b0, r_phi};
    assign w_z0    = {1'b0, w_angle, 16'd0};

    // cordic micro-rotation and final rounding to Q.14
    assign w_sh   = 5'(r_iter);
    assign w_xf   = r_neg ? -r_x : r_x;
    assign w_yf   = r_neg ? -r_y : r_y;
    assign w_crnd = (w_xf + 32'sd8192) >>> 14;
    assign w_srnd = (w_yf + 32'sd8192) >>> 14;

    // shared multiplier operands
    always_comb begin
        case (r_state)
            S_MUL_RS: begin
                w_mul_a = 32'(r_radius);
                w_mul_b = r_sin_phi;
            end
            S_MUL_X: begin
                w_mul_a = r_rs;
                w_mul_b = r_cos_th;
            end
            S_MUL_Y: begin
                w_mul_a = r_rs;
                w_mul_b = r_sin_th;
            end
            S_MUL_Z: begin
                w_mul_a = 32'(r_radius);
                w_mul_b = r_cos_phi;
            end
            default: begin
                w_mul_a = 32'sd0;
                w_mul_b = 18'sd0;
            end
        endcase
    end

    assign w_prod = 50'(w_mul_a) * 50'(w_mul_b);

    // round the last product, add the centre coordinate, saturate
    assign w_rnd28 = (r_prod + 50'sd134217728) >>> 28;
    assign w_rnd14 = (r_prod + 50'sd8192) >>> 14;
    assign w_rnd   = (r_state == S_FIN_Z) ? w_rnd14[21:0] : w_rnd28[21:0];

    always_comb begin
        case (r_state)
            S_MUL_Y: w_ctr = r_center_x;
            S_MUL_Z: w_ctr = r_center_y;
            default: w_ctr = r_center_z;
        endcase
    end

    assign w_fin = sat18(23'(w_rnd) + 23'(w_ctr));

    // state update arithmetic
    assign w_rsum     = 17'(r_radius) + 17'(r_op);
    assign w_phi_diff = 18'({4'd0, r_phi}) - 18'(r_op);

    // datapath next values
    always_comb begin
        n_radius    = r_radius;
        n_phi       = r_phi;
        n_theta     = r_theta;
        n_wrap      = r_wrap;
        n_pass      = r_pass;
        n_neg       = r_neg;
        n_iter      = r_iter;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_cos_phi   = r_cos_phi;
        n_sin_phi   = r_sin_phi;
        n_cos_th    = r_cos_th;
        n_sin_th    = r_sin_th;
        n_rs        = r_rs;
        n_prod      = r_prod;
        n_px        = r_px;
        n_py        = r_py;
        n_pz        = r_pz;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_z     = r_out_z;
        n_out_r     = r_out_r;
        n_out_phi   = r_out_phi;
        n_out_th    = r_out_th;
        n_out_valid = r_out_valid;

        if (r_out_valid && o_pos.ready) n_out_valid = 1'b0;

        case (r_state)
            // apply the command to radius and angles
            S_UPDATE: begin
                n_pass = 1'b0;
                n_wrap = 17'({2'd0, r_theta});
                case (r_mode)
                    MODE_SET_RADIUS: n_radius = r_op;
                    MODE_SET_PHI:    n_phi = clamp_phi(18'(r_op));
                    MODE_SET_THETA:  n_wrap = 17'(r_op);
                    MODE_ADD_RADIUS: begin
                        if (w_rsum > 17'sd32767) begin
                            n_radius = 16'sd32767;
                        end else if (w_rsum < -17'sd32768) begin
                            n_radius = -16'sd32768;
                        end else begin
                            n_radius = w_rsum[15:0];
                        end
                    end
                    MODE_SUB_PHI:    n_phi = clamp_phi(w_phi_diff);
                    MODE_ADD_THETA:  n_wrap = 17'({2'd0, r_theta}) + 17'(r_op);
                    default: ;
                endcase
            end
            // bring theta into [0, 2pi) one turn a cycle
            S_WRAP: begin
                if (r_wrap[16]) begin
                    n_wrap = r_wrap + THETA_WRAP;
                end else if (r_wrap >= THETA_WRAP) begin
                    n_wrap = r_wrap - THETA_WRAP;
                end else begin
                    n_theta = r_wrap[14:0];
                end
            end
            // load the rotator
            S_ROT_INIT: begin
                n_x    = GAIN_Q28;
                n_y    = 32'sd0;
                n_iter = '0;
                if (w_z0 > THR_HALF_PI_Q28) begin
                    n_z   = w_z0 - TWO_PI_Q28;
                    n_neg = 1'b0;
                end else if (w_z0 > HALF_PI_Q28) begin
                    n_z   = w_z0 - PI_Q28;
                    n_neg = 1'b1;
                end else begin
                    n_z   = w_z0;
                    n_neg = 1'b0;
                end
            end
            // one micro-rotation
            S_ROT_ITER: begin
                n_iter = r_iter + 1'b1;
                if (!r_z[31]) begin
                    n_x = r_x - (r_y >>> w_sh);
                    n_y = r_y + (r_x >>> w_sh);
                    n_z = r_z - atan_q28(w_sh);
                end else begin
                    n_x = r_x + (r_y >>> w_sh);
                    n_y = r_y - (r_x >>> w_sh);
                    n_z = r_z + atan_q28(w_sh);
                end
            end
            // keep cosine and sine of the angle just rotated
            S_ROT_DONE: begin
                n_pass = 1'b1;
                if (r_pass) begin
                    n_cos_th = w_crnd[17:0];
                    n_sin_th = w_srnd[17:0];
                end else begin
                    n_cos_phi = w_crnd[17:0];
                    n_sin_phi = w_srnd[17:0];
                end
            end
            S_MUL_RS: n_rs   = w_prod[31:0];
            S_MUL_X:  n_prod = w_prod;
            S_MUL_Y: begin
                n_px   = w_fin;
                n_prod = w_prod;
            end
            S_MUL_Z: begin
                n_py   = w_fin;
                n_prod = w_prod;
            end
            S_FIN_Z:  n_pz = w_fin;
            // hand the word to the output register
            S_OUT: begin
                if (w_load_out) begin
                    n_out_valid = 1'b1;
                    n_out_x     = r_px;
                    n_out_y     = r_py;
                    n_out_z     = r_pz;
                    n_out_r     = r_radius;
                    n_out_phi   = r_phi;
                    n_out_th    = r_theta;
                end
            end
            default: ;
        endcase
    end

    // control and orbit state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_radius    <= RADIUS_RESET;
            r_phi       <= PHI_RESET;
            r_theta     <= THETA_RESET;
            r_center_x  <= 16'sd0;
            r_center_y  <= 16'sd0;
            r_center_z  <= 16'sd0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_radius    <= n_radius;
            r_phi       <= n_phi;
            r_theta     <= n_theta;
            if (w_cfg_wr) begin
                case (paddr[3:2])
                    REG_CENTER_X: r_center_x <= pwdata[15:0];
                    REG_CENTER_Y: r_center_y <= pwdata[15:0];
                    REG_CENTER_Z: r_center_z <= pwdata[15:0];
                    default: ;
                endcase
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_mode <= i_cmd.mode;
            r_op   <= i_cmd.operand_value;
        end
        r_wrap    <= n_wrap;
        r_pass    <= n_pass;
        r_neg     <= n_neg;
        r_iter    <= n_iter;
        r_x       <= n_x;
        r_y       <= n_y;
        r_z       <= n_z;
        r_cos_phi <= n_cos_phi;
        r_sin_phi <= n_sin_phi;
        r_cos_th  <= n_cos_th;
        r_sin_th  <= n_sin_th;
        r_rs      <= n_rs;
        r_prod    <= n_prod;
        r_px      <= n_px;
        r_py      <= n_py;
        r_pz      <= n_pz;
        r_out_x   <= n_out_x;
        r_out_y   <= n_out_y;
        r_out_z   <= n_out_z;
        r_out_r   <= n_out_r;
        r_out_phi <= n_out_phi;
        r_out_th  <= n_out_th;
    end

endmodule
